### hdl/pe_base_reloc_parser_macros.svh
// Assertion macros for the base-relocation parser.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef PE_BASE_RELOC_PARSER_MACROS_SVH
`define PE_BASE_RELOC_PARSER_MACROS_SVH

// Property checked on every rising clock edge, masked while reset is high.
`define PBR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define PBR_NEVER(lbl, clk, rst, cond, msg) \
   `PBR_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

### hdl/pbr_pkg.sv
// Shared types and constants for the base-relocation parser.
// No dependencies; compiled first.
package pbr_pkg;

   localparam int HALFWORD_W = 16;
   localparam int KIND_W     = 2;
   localparam int OFFSET_W   = 32;
   localparam int DELTA_W    = 64;
   localparam int SIZE_W     = 32;
   localparam int ENTRIES_W  = 31;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_FIX       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END       = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MALFORMED = 2'd2;

   // Entry decode
   localparam logic [HALFWORD_W-1:0] TYPE_MASK   = 16'hF000;
   localparam logic [HALFWORD_W-1:0] TYPE_DIR64  = 16'hA000;
   localparam logic [HALFWORD_W-1:0] OFFSET_MASK = 16'h0FFF;
   localparam logic [SIZE_W-1:0]     HEADER_BYTES = 32'd8;

   // Parser phase: which header halfword comes next, or entries
   typedef enum logic [2:0] {
      PH_PAGE_LO = 3'd0,
      PH_PAGE_HI = 3'd1,
      PH_SIZE_LO = 3'd2,
      PH_SIZE_HI = 3'd3,
      PH_ENTRIES = 3'd4
   } phase_type;

   // One result beat between parser and output register
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [OFFSET_W-1:0] offset;
      logic [DELTA_W-1:0]  addend;
   } result_type;

endpackage

### hdl/pbr_req_if.sv
// Input channel: one table halfword per beat, valid/ready handshake.
// Depends on pbr_pkg for the field width.
interface pbr_req_if;
   logic                             valid;
   logic                             ready;
   logic [pbr_pkg::HALFWORD_W-1:0]   table_halfword;

   modport source (output valid, output table_halfword, input ready);
   modport sink   (input valid, input table_halfword, output ready);
endinterface

### hdl/pbr_rsp_if.sv
// Result channel: one fix, end or malformed result per beat, valid/ready handshake.
// Depends on pbr_pkg for the field widths.
interface pbr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pbr_pkg::KIND_W-1:0]     result_kind;
   logic [pbr_pkg::OFFSET_W-1:0]   fix_offset;
   logic [pbr_pkg::DELTA_W-1:0]    fix_addend;

   modport source (output valid, output result_kind, output fix_offset,
                   output fix_addend, input ready);
   modport sink   (input valid, input result_kind, input fix_offset,
                   input fix_addend, output ready);
endinterface

### hdl/pe_base_reloc_parser.sv
// Top level of the base-relocation table parser (DIR64 entries).
// Depends on pbr_pkg, pbr_req_if, pbr_rsp_if, pbr_parse and pbr_out_reg.
//
//   channel    direction  beat contents
//   req_beat   in         table_halfword[15:0]
//   rsp_beat   out        result_kind[1:0], fix_offset[31:0], fix_addend[63:0]
//   csr_wr_*   in         relocation_delta[63:0], write only
//
// One halfword is accepted per cycle while the parse stage can pass its beat on; its result,
// if any, passes through the input register, parse logic and output register.
// Reset is synchronous and clears the parse state, empties the output register and clears the delta.
// A stalled result holds the output register; the input register keeps accepting
// as long as the output register is free or draining in the same cycle.
module pe_base_reloc_parser (
   input  logic                         clock,
   input  logic                         reset,
   pbr_req_if.sink                      req_beat,
   pbr_rsp_if.source                    rsp_beat,
   input  logic                         csr_wr_en,
   input  logic [pbr_pkg::DELTA_W-1:0]  csr_wr_data
);
   import pbr_pkg::*;

   logic [DELTA_W-1:0] delta_ff;
   logic               out_free;
   logic               res_valid;
   result_type         res;

   // Relocation delta register
   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= '0;
      end else if (csr_wr_en) begin
         delta_ff <= csr_wr_data;
      end
   end

   pbr_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_beat.valid),
      .in_halfword (req_beat.table_halfword),
      .in_ready    (req_beat.ready),
      .delta       (delta_ff),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res)
   );

   pbr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_beat  (rsp_beat)
   );

endmodule

### hdl/pbr_parse.sv
// Input register and header/entry parser of the base-relocation parser.
// Depends on pbr_pkg and pe_base_reloc_parser_macros.svh.
`include "pe_base_reloc_parser_macros.svh"

module pbr_parse (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [pbr_pkg::HALFWORD_W-1:0]  in_halfword,
   output logic                            in_ready,
   input  logic [pbr_pkg::DELTA_W-1:0]     delta,
   input  logic                            out_free,
   output logic                            res_valid,
   output pbr_pkg::result_type             res
);
   import pbr_pkg::*;

   logic                     stage_valid_ff, stage_valid_in;
   logic [HALFWORD_W-1:0]    hw_ff;
   phase_type                phase_ff, phase_in;
   logic [OFFSET_W-1:0]      page_ff, page_in;
   logic [HALFWORD_W-1:0]    size_lo_ff, size_lo_in;
   logic [ENTRIES_W-1:0]     entries_ff, entries_in;
   logic                     finished_ff, finished_in;

   logic                     advance;
   logic [SIZE_W-1:0]        size;
   logic [SIZE_W-1:0]        size_body;
   logic                     is_end, is_malformed, is_fix;
   logic [ENTRIES_W-1:0]     entries_dec;

   // Input stage holds a beat until the output side can take its result
   assign advance        = stage_valid_ff && out_free;
   assign in_ready       = !stage_valid_ff || out_free;
   assign stage_valid_in = in_ready ? in_valid : stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (in_valid && in_ready) begin
         hw_ff <= in_halfword;
      end
   end

   // Header decode
   assign size         = {hw_ff, size_lo_ff};
   assign size_body    = size - HEADER_BYTES;
   assign is_end       = (size == '0) && (page_ff == '0);
   assign is_malformed = size < HEADER_BYTES;
   assign is_fix       = ((hw_ff & TYPE_MASK) == TYPE_DIR64) && (delta != '0);
   assign entries_dec  = (entries_ff != '0) ? entries_ff - 1'b1 : entries_ff;

   // Next state
   always_comb begin
      phase_in    = phase_ff;
      page_in     = page_ff;
      size_lo_in  = size_lo_ff;
      entries_in  = entries_ff;
      finished_in = finished_ff;
      if (advance && !finished_ff) begin
         unique case (phase_ff)
            PH_PAGE_LO: begin
               page_in  = {{(OFFSET_W-HALFWORD_W){1'b0}}, hw_ff};
               phase_in = PH_PAGE_HI;
            end
            PH_PAGE_HI: begin
               page_in  = {hw_ff, page_ff[HALFWORD_W-1:0]};
               phase_in = PH_SIZE_LO;
            end
            PH_SIZE_LO: begin
               size_lo_in = hw_ff;
               phase_in   = PH_SIZE_HI;
            end
            PH_SIZE_HI: begin
               if (is_end || is_malformed) begin
                  finished_in = 1'b1;
                  phase_in    = PH_PAGE_LO;
               end else begin
                  entries_in = size_body[SIZE_W-1:1];
                  phase_in   = (size_body[SIZE_W-1:1] != '0) ? PH_ENTRIES : PH_PAGE_LO;
               end
            end
            PH_ENTRIES: begin
               entries_in = entries_dec;
               if (entries_dec == '0) begin
                  phase_in = PH_PAGE_LO;
               end
            end
            default: begin
               phase_in = PH_PAGE_LO;
            end
         endcase
      end
   end

   // Result for the beat in the stage
   always_comb begin
      res_valid  = 1'b0;
      res.kind   = KIND_FIX;
      res.offset = '0;
      res.addend = '0;
      if (advance && !finished_ff) begin
         unique case (phase_ff)
            PH_SIZE_HI: begin
               if (is_end) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_END;
               end else if (is_malformed) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_MALFORMED;
               end
            end
            PH_ENTRIES: begin
               if (is_fix) begin
                  res_valid  = 1'b1;
                  res.offset = page_ff + {{(OFFSET_W-HALFWORD_W){1'b0}}, hw_ff & OFFSET_MASK};
                  res.addend = delta;
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PAGE_LO;
         page_ff     <= '0;
         size_lo_ff  <= '0;
         entries_ff  <= '0;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         page_ff     <= page_in;
         size_lo_ff  <= size_lo_in;
         entries_ff  <= entries_in;
         finished_ff <= finished_in;
      end
   end

   `PBR_NEVER(a_no_result_after_finish, clock, reset, finished_ff && res_valid, "result after table end")
   `PBR_ASSERT(a_entries_nonzero, clock, reset, (phase_ff == PH_ENTRIES) |-> (entries_ff != '0), "entry phase with no entries left")
   `PBR_ASSERT(a_finish_sticks, clock, reset, finished_ff |=> finished_ff, "finished flag cleared without reset")
   `PBR_NEVER(a_result_needs_room, clock, reset, res_valid && !out_free, "result with output register busy")

endmodule

### hdl/pbr_out_reg.sv
// Output register of the base-relocation parser: holds one result beat for the sink.
// Depends on pbr_pkg and pbr_rsp_if.
module pbr_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  pbr_pkg::result_type  res,
   output logic                 out_free,
   pbr_rsp_if.source            rsp_beat
);
   import pbr_pkg::*;

   logic       full_ff, full_in;
   result_type data_ff;

   // Register is free when empty or being drained this cycle
   assign out_free = !full_ff || rsp_beat.ready;
   assign full_in  = out_free ? res_valid : full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      if (out_free && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_beat.valid       = full_ff;
   assign rsp_beat.result_kind = data_ff.kind;
   assign rsp_beat.fix_offset  = data_ff.offset;
   assign rsp_beat.fix_addend  = data_ff.addend;

endmodule

### bench/tb_top.sv
// Testbench for pe_base_reloc_parser: streams relocation-table halfwords and
// checks every fix, end and malformed beat against a built-in parser model.
// Depends on pbr_pkg, pbr_req_if, pbr_rsp_if and the parser RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pbr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 6;
   localparam int REPORT_MAX   = 10;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [DELTA_W-1:0] csr_wr_data = '0;

   pbr_req_if req_beat ();
   pbr_rsp_if rsp_beat ();

   pe_base_reloc_parser DUT (
      .clock       (clock),
      .reset       (reset),
      .req_beat    (req_beat),
      .rsp_beat    (rsp_beat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Parser model state
   phase_type             parse_phase;
   logic [OFFSET_W-1:0]   block_page;
   logic [HALFWORD_W-1:0] size_low;
   logic [ENTRIES_W-1:0]  entries_left;
   logic                  table_done;
   logic [DELTA_W-1:0]    delta_model;

   logic [HALFWORD_W-1:0] halfwords_to_send[$];
   result_type            parse_results_due[$];

   int send_gap = 0;
   int stall_left = 0;
   int tx_calm = 0;
   int rx_calm = 0;
   int fault_count = 0;
   int cycle_count = 0;
   result_type seen_beat;
   result_type due_beat;

   initial begin
      req_beat.valid = 1'b0;
      req_beat.table_halfword = '0;
      rsp_beat.ready = 1'b0;
      parse_phase = PH_PAGE_LO;
      block_page = '0;
      size_low = '0;
      entries_left = '0;
      table_done = 1'b0;
      delta_model = '0;
   end

   initial begin
      forever #5 clock = ~clock;
   end

   // Advance the model by one accepted halfword; queue the result it causes
   function automatic void parse_halfword(input logic [HALFWORD_W-1:0] hw);
      logic [SIZE_W-1:0] block_size;
      result_type        r;
      r = '0;
      if (table_done)
         return;
      case (parse_phase)
         PH_PAGE_LO: begin
            block_page = {16'h0, hw};
            parse_phase = PH_PAGE_HI;
         end
         PH_PAGE_HI: begin
            block_page[31:16] = hw;
            parse_phase = PH_SIZE_LO;
         end
         PH_SIZE_LO: begin
            size_low = hw;
            parse_phase = PH_SIZE_HI;
         end
         PH_SIZE_HI: begin
            block_size = {hw, size_low};
            parse_phase = PH_PAGE_LO;
            if (block_size == '0 && block_page == '0) begin
               table_done = 1'b1;
               r.kind = KIND_END;
               parse_results_due.push_back(r);
            end else if (block_size < HEADER_BYTES) begin
               table_done = 1'b1;
               r.kind = KIND_MALFORMED;
               parse_results_due.push_back(r);
            end else begin
               block_size = (block_size - HEADER_BYTES) >> 1;
               entries_left = block_size[ENTRIES_W-1:0];
               if (entries_left != '0)
                  parse_phase = PH_ENTRIES;
            end
         end
         default: begin
            if (entries_left != '0)
               entries_left--;
            if (entries_left == '0)
               parse_phase = PH_PAGE_LO;
            if ((hw & TYPE_MASK) == TYPE_DIR64 && delta_model != '0) begin
               r.kind = KIND_FIX;
               r.offset = block_page + {16'h0, hw & OFFSET_MASK};
               r.addend = delta_model;
               parse_results_due.push_back(r);
            end
         end
      endcase
   endfunction

   // Mostly short gaps, a few long ones, and calm stretches with none
   function automatic int pick_gap(inout int calm_left);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if (roll < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic flag_fault(input string what, input result_type want, input result_type got);
      fault_count++;
      if (fault_count <= REPORT_MAX)
         $display("%0t: %s: want kind %0d off %h add %h, got kind %0d off %h add %h",
                  $time, what, want.kind, want.offset, want.addend,
                  got.kind, got.offset, got.addend);
   endtask

   // Sender: one halfword beat per handshake, predicted at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_beat.valid <= 1'b0;
         req_beat.table_halfword <= '0;
      end else begin
         if (req_beat.valid && req_beat.ready)
            parse_halfword(req_beat.table_halfword);
         if (!req_beat.valid || req_beat.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_beat.valid <= 1'b0;
            end else if (halfwords_to_send.size() != 0) begin
               req_beat.valid <= 1'b1;
               req_beat.table_halfword <= halfwords_to_send.pop_front();
               send_gap = pick_gap(tx_calm);
            end else begin
               req_beat.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_beat.ready <= 1'b0;
      end else begin
         if (rsp_beat.valid && rsp_beat.ready) begin
            seen_beat.kind = rsp_beat.result_kind;
            seen_beat.offset = rsp_beat.fix_offset;
            seen_beat.addend = rsp_beat.fix_addend;
            if (parse_results_due.size() == 0) begin
               flag_fault("result with nothing due", '0, seen_beat);
            end else begin
               due_beat = parse_results_due.pop_front();
               if (seen_beat.kind !== due_beat.kind || seen_beat.offset !== due_beat.offset ||
                   seen_beat.addend !== due_beat.addend)
                  flag_fault("result mismatch", due_beat, seen_beat);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_beat.ready <= 1'b0;
         end else begin
            rsp_beat.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall_left = pick_gap(rx_calm);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic queue_header(input logic [31:0] page, input logic [31:0] size_bytes);
      halfwords_to_send.push_back(page[15:0]);
      halfwords_to_send.push_back(page[31:16]);
      halfwords_to_send.push_back(size_bytes[15:0]);
      halfwords_to_send.push_back(size_bytes[31:16]);
   endtask

   function automatic logic [HALFWORD_W-1:0] random_entry();
      if ($urandom_range(0, 1) == 0)
         return TYPE_DIR64 | (HALFWORD_W'($urandom) & OFFSET_MASK);
      return HALFWORD_W'($urandom);
   endfunction

   function automatic logic [DELTA_W-1:0] pick_delta();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'd1;
         3: return 64'h8000_0000_0000_0000;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Block until everything sent has been answered and the pipeline has drained
   task automatic wait_idle();
      @(negedge clock);
      while (halfwords_to_send.size() != 0 || req_beat.valid || parse_results_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_delta(input logic [DELTA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      delta_model = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [HALFWORD_W-1:0] mixed_entries[8];
      logic [31:0] page;
      int          count;
      int          phase_items;
      int          ending;

      mixed_entries = '{16'hA000, 16'hAFFF, 16'h0000, 16'hFFFF,
                        16'h3123, 16'hB000, 16'h9FFF, 16'hA7A5};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: full delta, several entry types, wrap, empty and odd-sized blocks
      write_delta('1);
      queue_header(32'h0000_1000, 32'd24);
      foreach (mixed_entries[i])
         halfwords_to_send.push_back(mixed_entries[i]);
      queue_header(32'hFFFF_F800, 32'd12);
      halfwords_to_send.push_back(TYPE_DIR64 | OFFSET_MASK);
      halfwords_to_send.push_back(16'hA801);
      queue_header(32'h1234_5678, HEADER_BYTES);
      queue_header(32'h0000_0000, 32'd9);
      queue_header(32'hFFFF_FFFF, 32'd13);
      halfwords_to_send.push_back(16'hA001);
      halfwords_to_send.push_back(TYPE_DIR64 | OFFSET_MASK);
      wait_idle();

      // Zero delta: fix entries consumed silently
      write_delta('0);
      queue_header(32'h0000_2000, 32'd16);
      halfwords_to_send.push_back(16'hA010);
      halfwords_to_send.push_back(TYPE_DIR64 | OFFSET_MASK);
      halfwords_to_send.push_back(16'h0000);
      halfwords_to_send.push_back(TYPE_DIR64);
      wait_idle();
      write_delta(64'd1);

      // Random well-formed blocks, delta changed between phases
      for (int p = 0; p < 6; p++) begin
         if (p != 0)
            write_delta(pick_delta());
         phase_items = 0;
         while (phase_items < 55) begin
            case ($urandom_range(0, 9))
               8: page = 32'hFFFF_F000 | $urandom_range(0, 32'hFFF);
               9: page = $urandom_range(0, 255);
               default: page = $urandom;
            endcase
            count = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
            queue_header(page, HEADER_BYTES + 2 * count + ($urandom_range(0, 3) == 0));
            for (int e = 0; e < count; e++)
               halfwords_to_send.push_back(random_entry());
            phase_items += 4 + count;
         end
         wait_idle();
      end

      // Close the table one of several ways, then trailing beats that must be ignored, or leave an oversized block open
      if (delta_model == '0)
         write_delta(pick_delta() | 64'd1);
      ending = $urandom_range(0, 3);
      case (ending)
         0: queue_header(32'h0, 32'h0);
         1: queue_header($urandom | 32'h1, $urandom_range(0, 7));
         2: queue_header(32'h0, $urandom_range(1, 7));
         default: begin
            // oversized block left open: only its first entries are sent
            queue_header($urandom, {16'($urandom_range(1, 16'hFFFF)), 16'($urandom)});
            for (int e = 0; e < 40; e++)
               halfwords_to_send.push_back(random_entry());
         end
      endcase
      if (ending != 3) begin
         queue_header(32'h0, 32'h0);
         for (int e = 0; e < 12; e++)
            halfwords_to_send.push_back(random_entry());
      end
      wait_idle();
      repeat (20) @(negedge clock);

      if (parse_results_due.size() != 0)
         flag_fault("results never arrived", parse_results_due[0], '0);
      if (fault_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
